// ----- hdl/byte_fifo_with_token_read_assert.svh -----
// Assertion macros for the byte queue with token read.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef BYTE_FIFO_WITH_TOKEN_READ_ASSERT_SVH
`define BYTE_FIFO_WITH_TOKEN_READ_ASSERT_SVH

// ante implies cons in the same cycle
`define BFTR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// expr must never hold
`define BFTR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// ----- hdl/bftr_pkg.sv -----
// Shared types and constants for the byte queue with token read.
// No dependencies.
package bftr_pkg;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_GET   = 2'd1,
    KIND_TOKEN = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_NO_DELIM = 2'd2
  } status_e;

  localparam logic [7:0] DELIM_RESET = 8'd10;

endpackage

// ----- hdl/bftr_ram.sv -----
// Byte store: one write port, one read port with registered read data.
// No dependencies.
module bftr_ram #(
  parameter int DEPTH = 1024,
  parameter int PW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [PW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [PW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/byte_fifo_with_token_read.sv -----
// Top level of the circular byte queue with put, get, token read and clear.
// Uses bftr_pkg, bftr_ram and byte_fifo_with_token_read_assert.svh.
//
// Requests are taken when start_i is high and busy_o is low. Put and clear
// requests, refused or empty gets, and token requests on an empty queue
// are done without raising busy_o and may follow each other every cycle;
// their result is registered and shows in the cycle after acceptance. A get
// of N bytes holds busy_o while it reads them and emits one byte a cycle. A
// token request first scans the queue from the head through the byte store's
// single read port, one byte a cycle, until the delimiter or the end of the
// queue (L bytes), then emits the T bytes it takes; when it takes no byte,
// its single result follows the scan directly. Each result is on the outputs
// for exactly one cycle, marked by result_valid_o, and the receiver cannot
// stall it. The delimiter may be written at any time the block is idle.
`include "byte_fifo_with_token_read_assert.svh"

module byte_fifo_with_token_read #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_in_i,
  input  logic       burst_first_i,
  input  logic [6:0] amount_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] delimiter_i,
  output logic       result_valid_o,
  output logic [7:0] data_out_o,
  output logic       has_byte_o,
  output logic       last_o,
  output logic [1:0] status_o,
  output logic [6:0] read_count_o,
  output logic [9:0] occupancy_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int AW = ((PW > 7) ? PW : 7) + 2;
  localparam int OW = (PW > 10) ? PW : 10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [PW-1:0] fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] s;
    if (w >= r) begin
      s = {1'b0, w} - {1'b0, r};
    end else begin
      s = {1'b0, w} + (PW+1)'(DEPTH) - {1'b0, r};
    end
    return s[PW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [PW-1:0]       rd_q, rd_d, wr_q, wr_d;
  logic                burst_q, burst_d;
  logic [PW-1:0]       addr_q, addr_d;
  logic [PW-1:0]       issue_q, issue_d;
  logic [PW-1:0]       emit_q, emit_d;
  logic [PW-1:0]       len_q, len_d;
  logic [PW-1:0]       occ_q, occ_d;
  logic [6:0]          limit_q, limit_d;
  logic [6:0]          take_q, take_d;
  logic                token_q, token_d;
  bftr_pkg::status_e   stat_q, stat_d;
  logic [7:0]          delim_q;
  logic                rv_q, rd_en;

  logic                res_valid_q, res_valid_d;
  logic [7:0]          res_data_q, res_data_d;
  logic                res_has_q, res_has_d;
  logic                res_last_q, res_last_d;
  bftr_pkg::status_e   res_status_q, res_status_d;
  logic [6:0]          res_count_q, res_count_d;
  logic [9:0]          res_occ_q;

  logic                accept;
  logic [PW-1:0]       occ_cur;
  logic [OW-1:0]       occ_next;
  logic                mem_we;
  logic [7:0]          rdata;

  // scan bookkeeping
  logic [PW-1:0]       len_new;
  logic                hit, scan_done;
  logic [AW-1:0]       take_aw;
  logic                put_ok;
  logic [6:0]          lim;

  assign accept  = start_i && (state_q == S_IDLE);
  assign occ_cur = fill(wr_q, rd_q);
  assign len_new = len_q + 1'b1;
  assign hit     = (rdata == delim_q);
  assign scan_done = (state_q == S_SCAN) && rv_q && (hit || (len_new == occ_q));
  assign take_aw = (AW'(len_new) < AW'(limit_q)) ? AW'(len_new) : AW'(limit_q);

  bftr_ram #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_q),
    .wdata_i (data_in_i),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    burst_d  = burst_q;
    addr_d   = addr_q;
    issue_d  = issue_q;
    emit_d   = emit_q;
    len_d    = len_q;
    occ_d    = occ_q;
    limit_d  = limit_q;
    take_d   = take_q;
    token_d  = token_q;
    stat_d   = stat_q;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    put_ok   = 1'b0;
    lim      = '0;
    res_valid_d  = 1'b0;
    res_data_d   = '0;
    res_has_d    = 1'b0;
    res_last_d   = 1'b1;
    res_status_d = bftr_pkg::ST_OK;
    res_count_d  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (bftr_pkg::kind_e'(kind_i))
            bftr_pkg::KIND_PUT: begin
              if (burst_first_i) begin
                put_ok = (amount_i <= 7'(MAX_BURST)) &&
                         ((AW'(occ_cur) + AW'(amount_i)) < AW'(DEPTH - 1));
                burst_d = put_ok && (amount_i != '0);
                if (amount_i == '0) begin
                  res_status_d = put_ok ? bftr_pkg::ST_OK : bftr_pkg::ST_REFUSED;
                  put_ok = 1'b0;
                end else begin
                  res_status_d = put_ok ? bftr_pkg::ST_OK : bftr_pkg::ST_REFUSED;
                end
              end else begin
                put_ok = burst_q && ((AW'(occ_cur) + AW'(1)) < AW'(DEPTH - 1));
                res_status_d = put_ok ? bftr_pkg::ST_OK : bftr_pkg::ST_REFUSED;
              end
              if (put_ok) begin
                mem_we = 1'b1;
                wr_d   = ptr_inc(wr_q);
              end
            end
            bftr_pkg::KIND_GET: begin
              if ((amount_i > 7'(MAX_BURST)) || (AW'(amount_i) > AW'(occ_cur))) begin
                res_status_d = bftr_pkg::ST_REFUSED;
              end else if (amount_i != '0) begin
                res_valid_d = 1'b0;
                state_d = S_EMIT;
                addr_d  = rd_q;
                issue_d = PW'(amount_i);
                emit_d  = PW'(amount_i);
                token_d = 1'b0;
                stat_d  = bftr_pkg::ST_OK;
              end
            end
            bftr_pkg::KIND_TOKEN: begin
              lim = (amount_i > 7'(MAX_BURST)) ? 7'(MAX_BURST) : amount_i;
              if (occ_cur == '0) begin
                res_status_d = bftr_pkg::ST_NO_DELIM;
              end else begin
                res_valid_d = 1'b0;
                state_d = S_SCAN;
                addr_d  = rd_q;
                issue_d = occ_cur;
                len_d   = '0;
                occ_d   = occ_cur;
                limit_d = lim;
                token_d = 1'b1;
              end
            end
            bftr_pkg::KIND_CLEAR: begin
              rd_d    = '0;
              wr_d    = '0;
              burst_d = 1'b0;
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en = (issue_q != '0) && !scan_done;
        if (rd_en) begin
          addr_d  = ptr_inc(addr_q);
          issue_d = issue_q - 1'b1;
        end
        if (rv_q) begin
          len_d = len_new;
        end
        if (scan_done) begin
          stat_d  = hit ? bftr_pkg::ST_OK : bftr_pkg::ST_NO_DELIM;
          take_d  = 7'(take_aw);
          issue_d = PW'(take_aw);
          emit_d  = PW'(take_aw);
          addr_d  = rd_q;
          if (take_aw == '0) begin
            // nothing taken: single result straight after the scan
            res_valid_d  = 1'b1;
            res_status_d = hit ? bftr_pkg::ST_OK : bftr_pkg::ST_NO_DELIM;
            state_d      = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        rd_en = (issue_q != '0);
        if (rd_en) begin
          addr_d  = ptr_inc(addr_q);
          issue_d = issue_q - 1'b1;
        end
        if (rv_q) begin
          res_valid_d  = 1'b1;
          res_data_d   = rdata;
          res_has_d    = 1'b1;
          res_last_d   = (emit_q == PW'(1));
          res_status_d = stat_q;
          res_count_d  = (res_last_d && token_q) ? take_q : '0;
          rd_d   = ptr_inc(rd_q);
          emit_d = emit_q - 1'b1;
          if (res_last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign occ_next = OW'(fill(wr_d, rd_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_q         <= '0;
      wr_q         <= '0;
      burst_q      <= 1'b0;
      addr_q       <= '0;
      issue_q      <= '0;
      emit_q       <= '0;
      len_q        <= '0;
      occ_q        <= '0;
      limit_q      <= '0;
      take_q       <= '0;
      token_q      <= 1'b0;
      stat_q       <= bftr_pkg::ST_OK;
      delim_q      <= bftr_pkg::DELIM_RESET;
      rv_q         <= 1'b0;
      res_valid_q  <= 1'b0;
      res_data_q   <= '0;
      res_has_q    <= 1'b0;
      res_last_q   <= 1'b0;
      res_status_q <= bftr_pkg::ST_OK;
      res_count_q  <= '0;
      res_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      burst_q      <= burst_d;
      addr_q       <= addr_d;
      issue_q      <= issue_d;
      emit_q       <= emit_d;
      len_q        <= len_d;
      occ_q        <= occ_d;
      limit_q      <= limit_d;
      take_q       <= take_d;
      token_q      <= token_d;
      stat_q       <= stat_d;
      rv_q         <= rd_en;
      if (cfg_valid_i) begin
        delim_q <= delimiter_i;
      end
      res_valid_q  <= res_valid_d;
      res_data_q   <= res_data_d;
      res_has_q    <= res_has_d;
      res_last_q   <= res_last_d;
      res_status_q <= res_status_d;
      res_count_q  <= res_count_d;
      res_occ_q    <= occ_next[9:0];
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign data_out_o     = res_data_q;
  assign has_byte_o     = res_has_q;
  assign last_o         = res_last_q;
  assign status_o       = res_status_q;
  assign read_count_o   = res_count_q;
  assign occupancy_o    = res_occ_q;

  `BFTR_ASSERT_IMP(a_idle_result_last, res_valid_q && !busy_o, res_last_q)
  `BFTR_ASSERT_IMP(a_count_on_last, res_valid_q && (res_count_q != '0), res_last_q && res_has_q)
  `BFTR_ASSERT_IMP(a_scan_silent, state_q == S_SCAN, !res_valid_q)
  `BFTR_ASSERT_NEVER(a_never_full, occ_cur == PW'(DEPTH - 1))

endmodule

// ----- dv/byte_fifo_with_token_read_tb.sv -----
// Testbench for byte_fifo_with_token_read: random and directed requests checked
// against an in-bench model of the byte queue. Needs bftr_pkg and the RTL only.
module byte_fifo_with_token_read_tb;

  localparam int DEPTH     = 1024;
  localparam int MAX_BURST = 64;

  typedef struct {
    bftr_pkg::kind_e kind;
    logic [7:0]      data;
    logic            first;
    logic [6:0]      amount;
  } request_t;

  typedef struct {
    logic [7:0]        data;
    logic              has_byte;
    logic              last;
    bftr_pkg::status_e status;
    logic [6:0]        read_count;
    logic [9:0]        occupancy;
  } response_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start_i       = 1'b0;
  logic [1:0] kind_i        = bftr_pkg::KIND_PUT;
  logic [7:0] data_in_i     = '0;
  logic       burst_first_i = 1'b0;
  logic [6:0] amount_i      = '0;
  logic       cfg_valid_i   = 1'b0;
  logic [7:0] delimiter_i   = bftr_pkg::DELIM_RESET;
  logic       busy_o;
  logic       cfg_ready_o;
  logic       result_valid_o;
  logic [7:0] data_out_o;
  logic       has_byte_o;
  logic       last_o;
  logic [1:0] status_o;
  logic [6:0] read_count_o;
  logic [9:0] occupancy_o;

  byte_fifo_with_token_read dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .data_in_i      (data_in_i),
    .burst_first_i  (burst_first_i),
    .amount_i       (amount_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .delimiter_i    (delimiter_i),
    .result_valid_o (result_valid_o),
    .data_out_o     (data_out_o),
    .has_byte_o     (has_byte_o),
    .last_o         (last_o),
    .status_o       (status_o),
    .read_count_o   (read_count_o),
    .occupancy_o    (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  request_t  pending_reqs[$];
  response_t expected_resp[$];
  int        items_sent = 0;
  int        idle_pct   = 18;
  int        mismatches = 0;

  // model of the queue
  logic [7:0] shadow_store [DEPTH];
  logic [9:0] shadow_rd    = '0;
  logic [9:0] shadow_wr    = '0;
  logic       shadow_burst = 1'b0;
  logic [7:0] shadow_delim = bftr_pkg::DELIM_RESET;

  function automatic int shadow_fill();
    logic [9:0] diff;
    diff = shadow_wr - shadow_rd;
    return int'(diff);
  endfunction

  task automatic push_resp(input logic [7:0] d, input logic has, input logic fin,
                           input bftr_pkg::status_e st, input int cnt);
    response_t r;
    r.data       = d;
    r.has_byte   = has;
    r.last       = fin;
    r.status     = st;
    r.read_count = cnt[6:0];
    r.occupancy  = 10'(shadow_fill());
    expected_resp.push_back(r);
  endtask

  task automatic apply_request(input request_t req);
    int                occ;
    int                amt;
    int                len;
    int                take;
    logic              ok;
    logic              found;
    logic [9:0]        pos;
    logic [7:0]        b;
    bftr_pkg::status_e st;
    occ = shadow_fill();
    amt = int'(req.amount);
    case (req.kind)
      bftr_pkg::KIND_PUT: begin
        if (req.first) begin
          shadow_burst = (amt <= MAX_BURST) && (occ + amt < DEPTH - 1);
          ok = shadow_burst && amt > 0;
          if (amt == 0) begin
            st = shadow_burst ? bftr_pkg::ST_OK : bftr_pkg::ST_REFUSED;
            shadow_burst = 1'b0;
            push_resp(8'h00, 1'b0, 1'b1, st, 0);
            return;
          end
        end else begin
          ok = shadow_burst && (occ + 1 < DEPTH - 1);
        end
        if (ok) begin
          shadow_store[shadow_wr] = req.data;
          shadow_wr++;
        end
        push_resp(8'h00, 1'b0, 1'b1, ok ? bftr_pkg::ST_OK : bftr_pkg::ST_REFUSED, 0);
      end
      bftr_pkg::KIND_GET: begin
        if (amt > MAX_BURST || amt > occ) begin
          push_resp(8'h00, 1'b0, 1'b1, bftr_pkg::ST_REFUSED, 0);
        end else if (amt == 0) begin
          push_resp(8'h00, 1'b0, 1'b1, bftr_pkg::ST_OK, 0);
        end else begin
          for (int k = 0; k < amt; k++) begin
            b = shadow_store[shadow_rd];
            shadow_rd++;
            push_resp(b, 1'b1, k == amt - 1, bftr_pkg::ST_OK, 0);
          end
        end
      end
      bftr_pkg::KIND_TOKEN: begin
        pos   = shadow_rd;
        len   = 0;
        found = 1'b0;
        while (len < occ && !found) begin
          if (shadow_store[pos] == shadow_delim) found = 1'b1;
          pos++;
          len++;
        end
        if (amt > MAX_BURST) amt = MAX_BURST;
        take = (len < amt) ? len : amt;
        st   = found ? bftr_pkg::ST_OK : bftr_pkg::ST_NO_DELIM;
        if (take == 0) begin
          push_resp(8'h00, 1'b0, 1'b1, st, 0);
        end else begin
          for (int k = 0; k < take; k++) begin
            b = shadow_store[shadow_rd];
            shadow_rd++;
            push_resp(b, 1'b1, k == take - 1, st, (k == take - 1) ? take : 0);
          end
        end
      end
      default: begin
        shadow_rd    = '0;
        shadow_wr    = '0;
        shadow_burst = 1'b0;
        push_resp(8'h00, 1'b0, 1'b1, bftr_pkg::ST_OK, 0);
      end
    endcase
  endtask

  // driver
  request_t presented;
  always @(posedge clk_i) begin
    logic accepted;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (accepted) apply_request(presented);
      if (accepted || !start_i) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          presented = pending_reqs.pop_front();
          start_i       <= 1'b1;
          kind_i        <= presented.kind;
          data_in_i     <= presented.data;
          burst_first_i <= presented.first;
          amount_i      <= presented.amount;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: data %h has %b last %b status %0d count %0d occ %0d",
                   data_out_o, has_byte_o, last_o, status_o, read_count_o, occupancy_o);
      end else begin
        want = expected_resp.pop_front();
        if (data_out_o !== want.data || has_byte_o !== want.has_byte ||
            last_o !== want.last || status_o !== want.status ||
            read_count_o !== want.read_count || occupancy_o !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp data %h has %b last %b status %0d count %0d occ %0d",
                     want.data, want.has_byte, want.last, want.status,
                     want.read_count, want.occupancy);
            $display("          got data %h has %b last %b status %0d count %0d occ %0d",
                     data_out_o, has_byte_o, last_o, status_o, read_count_o, occupancy_o);
          end
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send(input bftr_pkg::kind_e k, input logic [7:0] d, input logic f,
                      input logic [6:0] a);
    request_t r;
    r.kind   = k;
    r.data   = d;
    r.first  = f;
    r.amount = a;
    pending_reqs.push_back(r);
    items_sent++;
  endtask

  function automatic logic [7:0] next_byte(input int delim_pct);
    if ($urandom_range(0, 99) < delim_pct) return shadow_delim;
    return 8'($urandom_range(0, 255));
  endfunction

  // first byte announces len, sent bytes actually follow
  task automatic put_burst(input int len, input int sent, input int delim_pct);
    send(bftr_pkg::KIND_PUT, next_byte(delim_pct), 1'b1, 7'(len));
    repeat (sent - 1)
      send(bftr_pkg::KIND_PUT, next_byte(delim_pct), 1'b0, 7'($urandom_range(0, 127)));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || start_i || busy_o || expected_resp.size() > 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_delimiter(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    delimiter_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    shadow_delim = v;
  endtask

  task automatic random_traffic(input int n);
    int stop;
    int occ;
    int len;
    int sent;
    int roll;
    int amt;
    stop = items_sent + n;
    while (items_sent < stop) begin
      while (pending_reqs.size() > 1) @(posedge clk_i);
      occ  = shadow_fill();
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
        sent = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len + 3) : len;
        put_burst(len, sent, 12);
      end else if (roll < 55) begin
        if (occ == 0 || $urandom_range(0, 4) == 0) amt = $urandom_range(0, 127);
        else amt = $urandom_range(1, (occ < MAX_BURST) ? occ : MAX_BURST);
        send(bftr_pkg::KIND_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             7'(amt));
      end else if (roll < 80) begin
        case ($urandom_range(0, 5))
          0:       amt = 0;
          1:       amt = $urandom_range(65, 127);
          default: amt = $urandom_range(1, 64);
        endcase
        send(bftr_pkg::KIND_TOKEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             7'(amt));
      end else if (roll < 88) begin
        send(bftr_pkg::KIND_PUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             7'($urandom_range(0, 127)));
      end else if (roll < 93) begin
        send(bftr_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             7'($urandom_range(0, 127)));
      end else begin
        send(bftr_pkg::KIND_PUT, 8'($urandom_range(0, 255)), 1'b1, 7'd0);
        send(bftr_pkg::KIND_PUT, 8'($urandom_range(0, 255)), 1'b0,
             7'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, zero and oversize requests, token cases
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd0);
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd1);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd5);
    send(bftr_pkg::KIND_PUT,   8'hFF, 1'b1, 7'd0);
    send(bftr_pkg::KIND_PUT,   8'hFF, 1'b0, 7'd1);
    send(bftr_pkg::KIND_PUT,   8'hFF, 1'b1, 7'd127);
    send(bftr_pkg::KIND_PUT,   8'h00, 1'b1, 7'd5);
    send(bftr_pkg::KIND_PUT,   8'hFF, 1'b0, 7'd0);
    send(bftr_pkg::KIND_PUT,   8'h0A, 1'b0, 7'd0);
    send(bftr_pkg::KIND_PUT,   8'hA5, 1'b0, 7'd0);
    send(bftr_pkg::KIND_PUT,   8'h5A, 1'b0, 7'd0);
    send(bftr_pkg::KIND_PUT,   8'h0A, 1'b0, 7'd0);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd0);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd2);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd64);
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd100);
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd2);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd127);
    send(bftr_pkg::KIND_PUT,   8'h11, 1'b1, 7'd64);
    send(bftr_pkg::KIND_PUT,   8'h22, 1'b0, 7'd0);
    send(bftr_pkg::KIND_PUT,   8'h33, 1'b0, 7'd0);
    send(bftr_pkg::KIND_TOKEN, 8'hFF, 1'b1, 7'd127);
    send(bftr_pkg::KIND_PUT,   8'h01, 1'b1, 7'd2);
    send(bftr_pkg::KIND_PUT,   8'h02, 1'b0, 7'd0);
    send(bftr_pkg::KIND_CLEAR, 8'h00, 1'b0, 7'd0);
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd0);
    wait_idle();

    write_delimiter(8'h00);
    random_traffic(110);
    wait_idle();

    // no idling: long bursts back to back, then token reads and gets
    write_delimiter(8'hFF);
    idle_pct = 0;
    send(bftr_pkg::KIND_CLEAR, 8'h00, 1'b0, 7'd0);
    put_burst(64, 64, 3);
    put_burst(8, 10, 3);
    send(bftr_pkg::KIND_PUT,   8'h00, 1'b1, 7'd0);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd127);
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd64);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd64);
    send(bftr_pkg::KIND_GET,   8'h00, 1'b0, 7'd37);
    send(bftr_pkg::KIND_TOKEN, 8'h00, 1'b0, 7'd100);
    wait_idle();

    idle_pct = 18;
    write_delimiter(8'($urandom_range(1, 254)));
    random_traffic(110);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
